// ===== rtl/core/mpk_pkg.sv =====
// Shared types, constants and saturation helper for the Mandelbrot pixel kernel.
`default_nettype none
package mpk_pkg;

    localparam int COLUMNS   = 84;
    localparam int ROWS      = 48;
    localparam int COL_W     = $clog2(COLUMNS);
    localparam int ROW_W     = $clog2(ROWS);
    localparam int BYTE_W    = $clog2((ROWS / 8) * COLUMNS);
    localparam int FRAC_BITS = 26;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CFG_IDX_W = 3;

    localparam logic [32:0] ESCAPE_RADIUS_SQ = 33'd4 << FRAC_BITS;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REAL_START = 3'd0,
        CFG_IMAG_START = 3'd1,
        CFG_REAL_STEP  = 3'd2,
        CFG_IMAG_STEP  = 3'd3,
        CFG_ITER_LIMIT = 3'd4
    } t_cfg_index;

    typedef struct packed {
        logic [31:0] real_start;
        logic [31:0] imag_start;
        logic [31:0] real_step;
        logic [31:0] imag_step;
        logic [7:0]  iteration_limit;
    } t_cfg;

    typedef struct packed {
        logic [31:0]       cr;
        logic [31:0]       ci;
        logic [BYTE_W-1:0] byte_index;
        logic [2:0]        bit_position;
    } t_job;

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] res;
        if (v > 40'sd2147483647) begin
            res = 32'sh7fffffff;
        end else if (v < -40'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/mandelbrot_pixel_kernel_top.sv =====
// Top level of the Mandelbrot pixel kernel: configuration registers and the front, queue, back.
// A pixel passes the front (capture, multiply, push), the queue, the back load state,
// the back states SQX, SQY, XY and UPD for each escape iteration, and the output register.
// The back end works on one pixel at a time on the single shared 32x32 multiplier, which issues
// the three products of each iteration before the update; the front takes new pixels meanwhile.
// Reset is synchronous and active low; it empties the queue and the result register
// and restores every configuration register to its default value.
`default_nettype none
module mandelbrot_pixel_kernel_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          push,
    output logic                               full,
    input  wire logic [mpk_pkg::COL_W-1:0]     i_column,
    input  wire logic [mpk_pkg::ROW_W-1:0]     i_pixel_row,
    output logic                               empty,
    input  wire logic                          pop,
    output logic [7:0]                         o_iteration_count,
    output logic                               o_pixel_set,
    output logic [mpk_pkg::BYTE_W-1:0]         o_byte_index,
    output logic [2:0]                         o_bit_position,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [mpk_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                   i_cfg_data
);

    mpk_pkg::t_cfg r_cfg;
    mpk_pkg::t_job w_front_job;
    mpk_pkg::t_job w_q_job;
    logic          w_q_push, w_q_full, w_q_pop, w_q_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.real_start      <= 32'hf8000000;
            r_cfg.imag_start      <= 32'hfc000000;
            r_cfg.real_step       <= 32'h00000000;
            r_cfg.imag_step       <= 32'h00000000;
            r_cfg.iteration_limit <= 8'd50;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (mpk_pkg::t_cfg_index'(i_cfg_index))
                mpk_pkg::CFG_REAL_START: r_cfg.real_start      <= i_cfg_data;
                mpk_pkg::CFG_IMAG_START: r_cfg.imag_start      <= i_cfg_data;
                mpk_pkg::CFG_REAL_STEP:  r_cfg.real_step       <= i_cfg_data;
                mpk_pkg::CFG_IMAG_STEP:  r_cfg.imag_step       <= i_cfg_data;
                mpk_pkg::CFG_ITER_LIMIT: r_cfg.iteration_limit <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    mpk_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .push        (push),
        .full        (full),
        .i_column    (i_column),
        .i_pixel_row (i_pixel_row),
        .o_q_push    (w_q_push),
        .i_q_full    (w_q_full),
        .o_q_job     (w_front_job)
    );

    mpk_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_job   (w_front_job),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_job   (w_q_job),
        .o_empty (w_q_empty)
    );

    mpk_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (r_cfg),
        .i_q_job           (w_q_job),
        .i_q_empty         (w_q_empty),
        .o_q_pop           (w_q_pop),
        .empty             (empty),
        .pop               (pop),
        .o_iteration_count (o_iteration_count),
        .o_pixel_set       (o_pixel_set),
        .o_byte_index      (o_byte_index),
        .o_bit_position    (o_bit_position)
    );

endmodule
`default_nettype wire

// ===== rtl/core/mpk_front.sv =====
// Front end: accepts a pixel, forms the point c and the frame buffer address.
`default_nettype none
module mpk_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire mpk_pkg::t_cfg             i_cfg,
    input  wire logic                      push,
    output logic                           full,
    input  wire logic [mpk_pkg::COL_W-1:0] i_column,
    input  wire logic [mpk_pkg::ROW_W-1:0] i_pixel_row,
    output logic                           o_q_push,
    input  wire logic                      i_q_full,
    output mpk_pkg::t_job                  o_q_job
);

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_MUL  = 3'b010,
        F_PUSH = 3'b100
    } t_front_state;

    t_front_state r_state, n_state;
    logic [mpk_pkg::COL_W-1:0] r_col;
    logic [mpk_pkg::ROW_W-1:0] r_row;
    logic signed [39:0]        r_prod_r;
    logic signed [39:0]        r_prod_i;
    logic [15:0]               w_byte;

    always_comb begin
        n_state = r_state;
        case (r_state)
            F_IDLE: begin
                if (push) begin
                    n_state = F_MUL;
                end
            end
            F_MUL: begin
                n_state = F_PUSH;
            end
            F_PUSH: begin
                if (!i_q_full) begin
                    n_state = F_IDLE;
                end
            end
            default: begin
                n_state = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == F_IDLE && push) begin
            r_col <= i_column;
            r_row <= i_pixel_row;
        end
        if (r_state == F_MUL) begin
            r_prod_r <= $signed({1'b0, r_col}) * $signed(i_cfg.real_step);
            r_prod_i <= $signed({1'b0, r_row}) * $signed(i_cfg.imag_step);
        end
    end

    assign w_byte = 16'(r_row[mpk_pkg::ROW_W-1:3]) * 16'(mpk_pkg::COLUMNS) + 16'(r_col);

    assign full                 = (r_state != F_IDLE);
    assign o_q_push             = (r_state == F_PUSH) && !i_q_full;
    assign o_q_job.cr           = mpk_pkg::sat32(r_prod_r + 40'($signed(i_cfg.real_start)));
    assign o_q_job.ci           = mpk_pkg::sat32(r_prod_i + 40'($signed(i_cfg.imag_start)));
    assign o_q_job.byte_index   = w_byte[mpk_pkg::BYTE_W-1:0];
    assign o_q_job.bit_position = r_row[2:0];

endmodule
`default_nettype wire

// ===== rtl/core/mpk_queue.sv =====
// Short job queue between the front end and the iteration engine.
`default_nettype none
module mpk_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire mpk_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output mpk_pkg::t_job      o_job,
    output logic               o_empty
);

    mpk_pkg::t_job              r_mem [mpk_pkg::QDEPTH];
    logic [mpk_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [mpk_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [mpk_pkg::QPTR_W:0]   r_count;
    logic                       w_do_push;
    logic                       w_do_pop;

    assign o_full    = (r_count == (mpk_pkg::QPTR_W + 1)'(mpk_pkg::QDEPTH));
    assign o_empty   = (r_count == '0);
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;
    assign o_job     = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == mpk_pkg::QPTR_W'(mpk_pkg::QDEPTH - 1)) ? '0
                                                                               : r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == mpk_pkg::QPTR_W'(mpk_pkg::QDEPTH - 1)) ? '0
                                                                               : r_rd_ptr + 1'b1;
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (mpk_pkg::QPTR_W + 1)'(mpk_pkg::QDEPTH))
        else $error("queue count exceeds depth");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into a full queue");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/mpk_back.sv =====
// Iteration engine: runs z = z*z + c on one shared multiplier and holds the result.
`default_nettype none
module mpk_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire mpk_pkg::t_cfg              i_cfg,
    input  wire mpk_pkg::t_job              i_q_job,
    input  wire logic                       i_q_empty,
    output logic                            o_q_pop,
    output logic                            empty,
    input  wire logic                       pop,
    output logic [7:0]                      o_iteration_count,
    output logic                            o_pixel_set,
    output logic [mpk_pkg::BYTE_W-1:0]      o_byte_index,
    output logic [2:0]                      o_bit_position
);

    typedef enum logic [5:0] {
        B_IDLE = 6'b000001,
        B_SQX  = 6'b000010,
        B_SQY  = 6'b000100,
        B_XY   = 6'b001000,
        B_UPD  = 6'b010000,
        B_DONE = 6'b100000
    } t_back_state;

    t_back_state r_state, n_state;
    logic signed [31:0]        r_cr, r_ci, r_x, r_y, r_xx, r_yy;
    logic signed [63:0]        r_p;
    logic [7:0]                r_count;
    logic [mpk_pkg::BYTE_W-1:0] r_byte;
    logic [2:0]                r_bit;
    logic                      r_out_valid;
    logic [7:0]                r_out_count;
    logic [mpk_pkg::BYTE_W-1:0] r_out_byte;
    logic [2:0]                r_out_bit;

    logic signed [31:0] w_op_a, w_op_b;
    logic signed [63:0] w_sq_shift, w_xy_shift;
    logic signed [31:0] w_sq_sat, w_xy2;
    logic [32:0]        w_modulus;
    logic               w_stop;
    logic               w_load_out;

    always_comb begin
        case (r_state)
            B_SQY: begin
                w_op_a = r_y;
                w_op_b = r_y;
            end
            B_XY: begin
                w_op_a = r_x;
                w_op_b = r_y;
            end
            default: begin
                w_op_a = r_x;
                w_op_b = r_x;
            end
        endcase
    end

    assign w_sq_shift = r_p >>> mpk_pkg::FRAC_BITS;
    assign w_xy_shift = r_p >>> (mpk_pkg::FRAC_BITS - 1);
    assign w_sq_sat   = mpk_pkg::sat32(w_sq_shift[39:0]);
    assign w_xy2      = mpk_pkg::sat32(w_xy_shift[39:0]);
    assign w_modulus  = {1'b0, r_xx} + {1'b0, r_yy};
    assign w_stop     = (w_modulus >= mpk_pkg::ESCAPE_RADIUS_SQ)
                        || (r_count >= i_cfg.iteration_limit);
    assign w_load_out = (r_state == B_DONE) && (!r_out_valid || pop);
    assign o_q_pop    = (r_state == B_IDLE) && !i_q_empty;

    always_comb begin
        n_state = r_state;
        case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    n_state = B_SQX;
                end
            end
            B_SQX: begin
                n_state = B_SQY;
            end
            B_SQY: begin
                n_state = B_XY;
            end
            B_XY: begin
                n_state = B_UPD;
            end
            B_UPD: begin
                n_state = w_stop ? B_DONE : B_SQX;
            end
            B_DONE: begin
                if (w_load_out) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load_out) begin
                r_out_valid <= 1'b1;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p <= w_op_a * w_op_b;
        case (r_state)
            B_IDLE: begin
                r_cr    <= i_q_job.cr;
                r_ci    <= i_q_job.ci;
                r_x     <= i_q_job.cr;
                r_y     <= i_q_job.ci;
                r_byte  <= i_q_job.byte_index;
                r_bit   <= i_q_job.bit_position;
                r_count <= 8'd1;
            end
            B_SQY: begin
                r_xx <= w_sq_sat;
            end
            B_XY: begin
                r_yy <= w_sq_sat;
            end
            B_UPD: begin
                if (!w_stop) begin
                    r_x     <= mpk_pkg::sat32(40'(r_xx) - 40'(r_yy) + 40'(r_cr));
                    r_y     <= mpk_pkg::sat32(40'(w_xy2) + 40'(r_ci));
                    r_count <= r_count + 8'd1;
                end
            end
            default: begin
            end
        endcase
        if (w_load_out) begin
            r_out_count <= r_count;
            r_out_byte  <= r_byte;
            r_out_bit   <= r_bit;
        end
    end

    assign empty             = !r_out_valid;
    assign o_iteration_count = r_out_count;
    assign o_pixel_set       = ~r_out_count[0];
    assign o_byte_index      = r_out_byte;
    assign o_bit_position    = r_out_bit;

`ifndef NO_ASSERTIONS
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_UPD && !w_stop) |=> (r_count == $past(r_count) + 8'd1))
        else $error("iteration count did not advance");
    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_count != 8'd0))
        else $error("result with zero iterations");
`endif

endmodule
`default_nettype wire
